[rtl/usd_pkg.sv]
// usd_pkg: item types, status codes and lead-byte classification for the
// utf-8 stream decoder; no dependencies
`default_nettype none

package usd_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadLead = 2'd1,
    StMissing = 2'd2,
    StTrunc   = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  seq_length;
    status_e     status;
    logic        last_of_run;
  } out_t;

  // results of one byte handed from front to queue
  typedef struct packed {
    logic [1:0] cnt;
    out_t       r0;
    out_t       r1;
  } push_t;

  typedef struct packed {
    logic        is_ascii;
    logic        is_bad;
    logic [2:0]  len;
    logic [20:0] init;
  } lead_t;

  localparam logic [7:0] MaskTop1 = 8'b1000_0000;
  localparam logic [7:0] MaskTop2 = 8'b1100_0000;
  localparam logic [7:0] MaskTop3 = 8'b1110_0000;
  localparam logic [7:0] MaskTop4 = 8'b1111_0000;
  localparam logic [7:0] MaskTop5 = 8'b1111_1000;

  function automatic lead_t lead_decode(logic [7:0] b);
    lead_t l;
    l = '0;
    if ((b & MaskTop1) == 8'h00) begin
      l.is_ascii = 1'b1;
      l.len      = 3'd1;
      l.init     = {13'd0, b};
    end else if ((b & MaskTop3) == MaskTop2) begin
      l.len  = 3'd2;
      l.init = {16'd0, b[4:0]};
    end else if ((b & MaskTop4) == MaskTop3) begin
      l.len  = 3'd3;
      l.init = {17'd0, b[3:0]};
    end else if ((b & MaskTop5) == MaskTop4) begin
      l.len  = 3'd4;
      l.init = {18'd0, b[2:0]};
    end else begin
      l.is_bad = 1'b1;
      l.len    = 3'd1;
    end
    return l;
  endfunction

  function automatic out_t mk_res(logic [20:0] cp, logic [2:0] len, status_e st);
    out_t r;
    r.code_point  = cp;
    r.seq_length  = len;
    r.status      = st;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/utf8_stream_decoder_core.sv]
// utf8_stream_decoder_core: top level of the utf-8 stream decoder
// throughput: one byte per cycle while the queue is not full; one result per cycle leaves
// the output while the consumer does not stall, so the two results of a byte leave in turn
// a byte's results are written to the queue at the edge that accepts it and move into the
// output register once that register is empty or its result is taken
// reset: asynchronous, clears the pending sequence, the queue and output valid
`default_nettype none

module utf8_stream_decoder_core #(
  parameter int unsigned QDepth = usd_pkg::QueueDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire usd_pkg::in_t   in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output usd_pkg::out_t       out_data_o
);
  import usd_pkg::*;

  localparam int unsigned CntW = $clog2(QDepth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(QDepth);

  push_t           push;
  out_t            q_head;
  logic            q_empty;
  logic            q_full;
  logic            pop;
  logic [CntW-1:0] q_count;

  // the input stalls only on queue occupancy, never on the output side
  assign in_stall_o = q_full;

  // front: holds the partial sequence and turns a byte into its results
  usd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (q_full),
    .in_data_i  (in_data_i),
    .push_o     (push)
  );

  // queue: decouples byte acceptance from result delivery
  usd_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (q_head),
    .empty_o (q_empty),
    .full_o  (q_full),
    .count_o (q_count)
  );

  // back: output register toward the consumer
  usd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // nothing is written while the input is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (push.cnt == 2'd0))
    else $error("push while input stalled");

  // queue occupancy stays within its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= DepthC)
    else $error("queue overflow");

  // a byte never gives more than two results, and only the last is marked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt == 2'd2) |-> (push.r1.last_of_run && !push.r0.last_of_run))
    else $error("last_of_run on wrong result");

  // an error result never carries a code point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != StOk)) |-> (out_data_o.code_point == 21'd0))
    else $error("error result with nonzero code point");

endmodule

`default_nettype wire

[rtl/usd_front.sv]
// usd_front: accepts bytes, keeps the pending sequence and classifies each
// byte into zero, one or two results; depends on usd_pkg
`default_nettype none

module usd_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_stall_i,
  input  wire usd_pkg::in_t   in_data_i,
  output usd_pkg::push_t      push_o
);
  import usd_pkg::*;

  logic [2:0]  exp_q, exp_d;
  logic [2:0]  seen_q, seen_d;
  logic [20:0] part_q, part_d;

  logic        accept;
  lead_t       lead;
  logic [7:0]  b;
  logic        fin;
  logic [20:0] part_new;
  logic [2:0]  seen_new;
  out_t        lead_res;
  logic        lead_emit;
  push_t       push;

  assign accept   = in_valid_i && !in_stall_i;
  assign b        = in_data_i.data_byte;
  assign fin      = in_data_i.final_byte;
  assign lead     = lead_decode(b);
  assign part_new = {part_q[14:0], b[5:0]};
  assign seen_new = seen_q + 3'd1;

  always_comb begin
    exp_d     = exp_q;
    seen_d    = seen_q;
    part_d    = part_q;
    push      = '0;
    lead_res  = '0;
    lead_emit = 1'b0;

    // what the byte does when taken as a lead byte
    if (lead.is_ascii) begin
      lead_res  = mk_res(lead.init, 3'd1, StOk);
      lead_emit = 1'b1;
    end else if (lead.is_bad) begin
      lead_res  = mk_res(21'd0, 3'd1, StBadLead);
      lead_emit = 1'b1;
    end else if (fin) begin
      lead_res  = mk_res(21'd0, 3'd1, StTrunc);
      lead_emit = 1'b1;
    end

    if (accept) begin
      if (exp_q == 3'd0) begin
        if (lead_emit) begin
          push.cnt = 2'd1;
          push.r0  = lead_res;
        end else begin
          exp_d  = lead.len;
          seen_d = 3'd1;
          part_d = lead.init;
        end
      end else if ((b & MaskTop2) == MaskTop1) begin
        if (seen_new >= exp_q) begin
          push.cnt = 2'd1;
          push.r0  = mk_res(part_new, exp_q, StOk);
          exp_d    = 3'd0;
          seen_d   = 3'd0;
          part_d   = '0;
        end else if (fin) begin
          push.cnt = 2'd1;
          push.r0  = mk_res(21'd0, seen_new, StTrunc);
          exp_d    = 3'd0;
          seen_d   = 3'd0;
          part_d   = '0;
        end else begin
          seen_d = seen_new;
          part_d = part_new;
        end
      end else begin
        // interrupted sequence, then the byte starts over as a lead
        push.r0 = mk_res(21'd0, seen_q, StMissing);
        if (lead_emit) begin
          push.cnt = 2'd2;
          push.r1  = lead_res;
          exp_d    = 3'd0;
          seen_d   = 3'd0;
          part_d   = '0;
        end else begin
          push.cnt = 2'd1;
          exp_d    = lead.len;
          seen_d   = 3'd1;
          part_d   = lead.init;
        end
      end
    end

    if (push.cnt == 2'd1) begin
      push.r0.last_of_run = 1'b1;
    end else if (push.cnt == 2'd2) begin
      push.r1.last_of_run = 1'b1;
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q  <= 3'd0;
      seen_q <= 3'd0;
      part_q <= '0;
    end else begin
      exp_q  <= exp_d;
      seen_q <= seen_d;
      part_q <= part_d;
    end
  end

endmodule

`default_nettype wire

[rtl/usd_queue.sv]
// usd_queue: short result queue between front and back, up to two writes
// and one read a cycle; depends on usd_pkg
`default_nettype none

module usd_queue #(
  parameter int unsigned Depth = usd_pkg::QueueDepth,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire usd_pkg::push_t   push_i,
  input  wire logic             pop_i,
  output usd_pkg::out_t         head_o,
  output logic                  empty_o,
  output logic                  full_o,
  output logic [CntW-1:0]       count_o
);
  import usd_pkg::*;

  localparam logic [PtrW-1:0] LastIdx  = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FreeLim  = CntW'(Depth - 2);

  out_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_nx;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  function automatic logic [PtrW-1:0] inc(logic [PtrW-1:0] p);
    return (p == LastIdx) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_nx   = inc(wr_q);
  assign do_pop  = pop_i && (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  // room for two results keeps the front free of any per-byte look-ahead
  assign full_o  = (cnt_q > FreeLim);
  assign count_o = cnt_q;

  always_comb begin
    wr_d = wr_q;
    if (push_i.cnt == 2'd1) begin
      wr_d = wr_nx;
    end else if (push_i.cnt == 2'd2) begin
      wr_d = inc(wr_nx);
    end
    rd_d  = do_pop ? inc(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.cnt) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nx] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[rtl/usd_back.sv]
// usd_back: output register that drains the result queue onto the output
// channel; depends on usd_pkg
`default_nettype none

module usd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_empty_i,
  input  wire usd_pkg::out_t  q_head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output usd_pkg::out_t       out_data_o
);
  import usd_pkg::*;

  logic valid_q, valid_d;
  out_t data_q;

  assign pop_o   = !q_empty_i && (!valid_q || !out_stall_i);
  assign valid_d = pop_o || (valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= q_head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire
